// ----- design/sft_pkg.sv -----
// Shared types and constants for the symbol frequency table.
`timescale 1ns / 1ps

package sft_pkg;

  localparam int unsigned SYM_W     = 8;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned USED_W    = 9;
  localparam int unsigned OUT_CNT_W = 32;
  localparam int unsigned SYM_NUM   = 1 << SYM_W;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  sym;
    logic [SLOT_W-1:0] slot;
  } map_wr_t;

endpackage

// ----- design/sft_slot_map.sv -----
// Symbol-indexed slot map with a seen bit per symbol and registered read data.
`timescale 1ns / 1ps

module sft_slot_map
  import sft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SYM_W-1:0]  rd_sym_i,
  input  map_wr_t           wr_i,
  output logic              seen_o,
  output logic [SLOT_W-1:0] slot_o
);

  logic [SYM_NUM-1:0] seen_q;
  logic [SLOT_W-1:0]  slot_mem [SYM_NUM];
  logic               seen_rd_q;
  logic [SLOT_W-1:0]  slot_rd_q;

  // The seen bits are flops so that reset empties the table at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      seen_rd_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        seen_q[wr_i.sym] <= 1'b1;
      end
      if (rd_en_i) begin
        seen_rd_q <= seen_q[rd_sym_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      slot_mem[wr_i.sym] <= wr_i.slot;
    end
    if (rd_en_i) begin
      slot_rd_q <= slot_mem[rd_sym_i];
    end
  end

  assign seen_o = seen_rd_q;
  assign slot_o = slot_rd_q;

endmodule

// ----- design/sft_count_ram.sv -----
// Count memory indexed by symbol, one write and one registered read port.
`timescale 1ns / 1ps

module sft_count_ram
  import sft_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [SYM_W-1:0] rd_addr_i,
  input  logic             wr_en_i,
  input  logic [SYM_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [SYM_NUM];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ----- design/symbol_frequency_table_unit.sv -----
// Top level of the symbol frequency table: control, update logic and result register.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i, in_ready_o | symbol_i
//  out     | out_valid_o, out_ready_i | slot_index_o, symbol_count_o, first_seen_o,
//          |                        | distinct_total_o
//
// Each request passes through a registered read of the slot map and the count memory,
// then an update of them that also loads the result register.
// Reset clears the seen bits and the fill count at once; there is no clearing pass.
// A new request is taken while a result still waits; the update cycle holds only while
// the result register is full and not being drained.
`timescale 1ns / 1ps

module symbol_frequency_table_unit
  import sft_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [SYM_W-1:0]     symbol_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SLOT_W-1:0]    slot_index_o,
  output logic [OUT_CNT_W-1:0] symbol_count_o,
  output logic                 first_seen_o,
  output logic [USED_W-1:0]    distinct_total_o
);

  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [USED_W-1:0]      DepthLim = USED_W'(TABLE_DEPTH);

  state_e                 state_q, state_d;
  logic [SYM_W-1:0]       sym_q;
  logic [USED_W-1:0]      used_q, used_d;
  logic                   accept;
  logic                   commit;
  logic                   rd_en;
  logic                   seen;
  logic [SLOT_W-1:0]      slot_rd;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic                   full;
  map_wr_t                map_wr;
  logic                   cnt_we;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [SLOT_W-1:0]      slot_new;
  logic                   first_new;
  logic [63:0]            cnt_wide;

  logic                   out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]      slot_q;
  logic [OUT_CNT_W-1:0]   count_q;
  logic                   first_q;
  logic [USED_W-1:0]      total_q;

  sft_slot_map u_slot_map (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_sym_i (symbol_i),
    .wr_i     (map_wr),
    .seen_o   (seen),
    .slot_o   (slot_rd)
  );

  sft_count_ram #(
    .WIDTH (COUNT_WIDTH)
  ) u_count_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (symbol_i),
    .wr_en_i   (cnt_we),
    .wr_addr_i (sym_q),
    .wr_data_i (cnt_new),
    .rd_data_o (cnt_rd)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs of the state machine.
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready_o = 1'b1;
      ST_UPDATE: commit     = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign rd_en  = accept;
  assign full   = (used_q >= DepthLim);

  // Update of the looked-up entry.
  always_comb begin
    map_wr    = '0;
    cnt_we    = 1'b0;
    cnt_new   = '0;
    slot_new  = '0;
    first_new = 1'b0;
    used_d    = used_q;
    if (seen) begin
      cnt_new  = (cnt_rd == CountMax) ? cnt_rd : cnt_rd + COUNT_WIDTH'(1);
      slot_new = slot_rd;
      cnt_we   = commit;
    end else if (!full) begin
      // A new symbol takes the next free slot with a count of one.
      cnt_new     = COUNT_WIDTH'(1);
      slot_new    = used_q[SLOT_W-1:0];
      first_new   = 1'b1;
      cnt_we      = commit;
      map_wr.en   = commit;
      map_wr.sym  = sym_q;
      map_wr.slot = used_q[SLOT_W-1:0];
      if (commit) begin
        used_d = used_q + USED_W'(1);
      end
    end
  end

  assign cnt_wide    = 64'(cnt_new);
  assign out_valid_d = commit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q <= symbol_i;
    end
    if (commit) begin
      slot_q  <= slot_new;
      count_q <= cnt_wide[OUT_CNT_W-1:0];
      first_q <= first_new;
      total_q <= used_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign slot_index_o     = slot_q;
  assign symbol_count_o   = count_q;
  assign first_seen_o     = first_q;
  assign distinct_total_o = total_q;

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= DepthLim)
    else $error("fill count beyond table depth");

  a_fill_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(used_q))
    else $error("fill count changed without an update");

  a_accept_to_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_UPDATE)
    else $error("accepted request did not reach the update cycle");

  a_new_has_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_seen_o |-> symbol_count_o == OUT_CNT_W'(1) &&
      distinct_total_o == USED_W'(slot_index_o) + USED_W'(1))
    else $error("new symbol result is inconsistent");

endmodule

// ----- tb/symbol_frequency_table_unit_tb.sv -----
// Testbench for the symbol frequency table: random symbol requests checked against a predictor.
`timescale 1ns / 1ps

module symbol_frequency_table_unit_tb;
  import sft_pkg::*;

  localparam int unsigned TABLE_DEPTH  = 256;
  localparam int unsigned COUNT_WIDTH  = 32;
  localparam int unsigned PHASE_ITEMS  = 545;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [SLOT_W-1:0]    slot;
    logic [OUT_CNT_W-1:0] count;
    logic                 first;
    logic [USED_W-1:0]    total;
  } freq_result_t;

  class freq_scoreboard;
    bit [SYM_W-1:0]       slot_sym[TABLE_DEPTH];
    bit [COUNT_WIDTH-1:0] slot_cnt[TABLE_DEPTH];
    int unsigned          used;
    int unsigned          errors;
    freq_result_t         expected_q[$];

    // Works out the result of one accepted request and updates the table copy.
    function void note_request(logic [SYM_W-1:0] sym);
      freq_result_t exp_res;
      int unsigned  hit;
      bit           found;
      found = 1'b0;
      hit   = 0;
      for (int unsigned i = 0; i < used; i++) begin
        if (!found && slot_sym[i] == sym) begin
          found = 1'b1;
          hit   = i;
        end
      end
      if (found) begin
        if (slot_cnt[hit] != '1) begin
          slot_cnt[hit]++;
        end
        exp_res.slot  = SLOT_W'(hit);
        exp_res.count = OUT_CNT_W'(slot_cnt[hit]);
        exp_res.first = 1'b0;
      end else if (used < TABLE_DEPTH) begin
        slot_sym[used] = sym;
        slot_cnt[used] = 1;
        exp_res.slot   = SLOT_W'(used);
        exp_res.count  = 1;
        exp_res.first  = 1'b1;
        used++;
      end else begin
        // Table full: the symbol is dropped and a zero count marks the error.
        exp_res.slot  = '0;
        exp_res.count = '0;
        exp_res.first = 1'b0;
      end
      exp_res.total = USED_W'(used);
      expected_q.push_back(exp_res);
    endfunction

    function void compare_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
      if (got_val !== exp_val) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, got_val);
        errors++;
      end
    endfunction

    function void check_result(logic [SLOT_W-1:0] slot, logic [OUT_CNT_W-1:0] count,
                               logic first, logic [USED_W-1:0] total);
      freq_result_t exp_res;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual slot %0d count %0d",
                 $time, slot, count);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      compare_field("slot_index", 64'(exp_res.slot), 64'(slot));
      compare_field("symbol_count", 64'(exp_res.count), 64'(count));
      compare_field("first_seen", 64'(exp_res.first), 64'(first));
      compare_field("distinct_total", 64'(exp_res.total), 64'(total));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [SYM_W-1:0]     symbol_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SLOT_W-1:0]    slot_index_o;
  logic [OUT_CNT_W-1:0] symbol_count_o;
  logic                 first_seen_o;
  logic [USED_W-1:0]    distinct_total_o;

  freq_scoreboard sb = new();

  int unsigned    tx_idle_pct   = 0;
  int unsigned    rx_idle_pct   = 0;
  bit             long_hold_req = 1'b0;
  bit             long_hold_done = 1'b0;
  int unsigned    hold_left     = 0;
  int unsigned    cycle_cnt     = 0;
  logic [SYM_W-1:0] sym_order[SYM_NUM];
  int unsigned    order_pos     = 0;
  logic [SYM_W-1:0] hot_sym[4];

  symbol_frequency_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .symbol_i        (symbol_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_index_o    (slot_index_o),
    .symbol_count_o  (symbol_count_o),
    .first_seen_o    (first_seen_o),
    .distinct_total_o(distinct_total_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("symbol_frequency_table_unit_tb failed");
      $finish;
    end
  end

  // Result side: check accepted results, then decide ready for the next cycle.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(slot_index_o, symbol_count_o, first_seen_o, distinct_total_o);
    end
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_symbol(input logic [SYM_W-1:0] sym);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i   <= sym;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(sym);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mix of fresh symbols in shuffled order (fills the table), a few hot symbols that
  // pile up counts and collide in the pipeline, and uniform noise.
  function automatic logic [SYM_W-1:0] pick_symbol();
    int unsigned r;
    logic [SYM_W-1:0] sym;
    r = $urandom_range(99);
    if (r < 30) begin
      sym       = sym_order[order_pos % SYM_NUM];
      order_pos = order_pos + 1;
    end else if (r < 75) begin
      sym = hot_sym[$urandom_range(3)];
    end else begin
      sym = SYM_W'($urandom_range(SYM_NUM - 1));
    end
    return sym;
  endfunction

  initial begin
    logic [SYM_W-1:0] directed[20];
    logic [SYM_W-1:0] tmp;
    int unsigned      j;
    directed = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h55, 8'h01, 8'h80,
                 8'h7F, 8'hFE, 8'h01, 8'h01, 8'h01, 8'hAA, 8'h00, 8'hFF, 8'h40, 8'h40};
    for (int unsigned i = 0; i < SYM_NUM; i++) begin
      sym_order[i] = SYM_W'(i);
    end
    for (int unsigned i = SYM_NUM - 1; i > 0; i--) begin
      j            = $urandom_range(i);
      tmp          = sym_order[i];
      sym_order[i] = sym_order[j];
      sym_order[j] = tmp;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Back-to-back requests with no idling, including repeats of one symbol.
    foreach (directed[k]) begin
      send_symbol(directed[k]);
    end

    for (int unsigned p = 0; p < 3; p++) begin
      tx_idle_pct = (p == 0) ? 29 : (p == 1) ? 59 : 0;
      rx_idle_pct = (p == 0) ? 59 : (p == 1) ? 29 : 0;
      foreach (hot_sym[k]) begin
        hot_sym[k] = SYM_W'($urandom_range(SYM_NUM - 1));
      end
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 200) begin
          long_hold_req = 1'b1;
        end
        if (p == 1 && i == 270) begin
          wait_drained();
        end
        send_symbol(pick_symbol());
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("symbol_frequency_table_unit_tb passed");
    end else begin
      $display("symbol_frequency_table_unit_tb failed");
    end
    $finish;
  end

endmodule
